// File: src/mtw_pkg.sv
// Package for the MT19937 word generator: word type, twist and tempering
// constants, seeding constants and the seeder control struct. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mtw_pkg;

  typedef logic [31:0] word_t;

  localparam int STATE_WORDS   = 624;
  localparam int MIDDLE_OFFSET = 397;

  localparam word_t TWIST_XOR  = 32'h9908_b0df;
  localparam word_t HIGH_BIT   = 32'h8000_0000;
  localparam word_t LOW_BITS   = 32'h7fff_ffff;
  localparam word_t TEMPER_B   = 32'h9d2c_5680;
  localparam word_t TEMPER_C   = 32'hefc6_0000;
  localparam word_t LCG_MUL    = 32'd69069;
  localparam word_t LCG_INC    = 32'd1;
  localparam word_t SEED_RESET = 32'd4357;

  typedef struct packed {
    logic load;
    logic run;
  } seed_ctrl_t;

endpackage
`default_nettype wire

// File: src/mtw_cell.sv
// One state word of the generator chain; takes its input word (its neighbor's, or the new word at the tail) on shift.
// Depends on mtw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mtw_cell (
  input  wire logic          clk,
  input  wire logic          shift_en,
  input  wire mtw_pkg::word_t d_in,
  output mtw_pkg::word_t      q_out
);

  mtw_pkg::word_t word_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      word_r <= d_in;
    end
  end

  assign q_out = word_r;

endmodule
`default_nettype wire

// File: src/mtw_seeder.sv
// Linear-congruential seeder: one step per cycle while run is set; each state word
// joins the upper halves of two successive values. Depends on mtw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mtw_seeder (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mtw_pkg::seed_ctrl_t ctrl,
  input  wire mtw_pkg::word_t      seed,
  output mtw_pkg::word_t           word_out,
  output logic                     word_valid
);

  mtw_pkg::word_t lcg_r;
  mtw_pkg::word_t lcg_nxt;
  logic [15:0]    hi_r;
  logic           phase_r;

  assign lcg_nxt = lcg_r * mtw_pkg::LCG_MUL + mtw_pkg::LCG_INC;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
    end else if (ctrl.load) begin
      phase_r <= 1'b0;
    end else if (ctrl.run) begin
      phase_r <= ~phase_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      lcg_r <= seed;
    end else if (ctrl.run) begin
      lcg_r <= lcg_nxt;
      if (!phase_r) begin
        hi_r <= lcg_r[31:16];
      end
    end
  end

  assign word_out   = {hi_r, lcg_r[31:16]};
  assign word_valid = ctrl.run & phase_r;

endmodule
`default_nettype wire

// File: src/mtw_twist.sv
// Twist rule for one new state word and the tempering of that word.
// Depends on mtw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mtw_twist (
  input  wire mtw_pkg::word_t upper,
  input  wire mtw_pkg::word_t lower,
  input  wire mtw_pkg::word_t far,
  output mtw_pkg::word_t      new_word,
  output mtw_pkg::word_t      tempered
);

  mtw_pkg::word_t y;
  mtw_pkg::word_t t1;
  mtw_pkg::word_t t2;
  mtw_pkg::word_t t3;

  always_comb begin
    y        = (upper & mtw_pkg::HIGH_BIT) | (lower & mtw_pkg::LOW_BITS);
    new_word = far ^ (y >> 1) ^ (y[0] ? mtw_pkg::TWIST_XOR : '0);
    t1       = new_word ^ (new_word >> 11);
    t2       = t1 ^ ((t1 << 7) & mtw_pkg::TEMPER_B);
    t3       = t2 ^ ((t2 << 15) & mtw_pkg::TEMPER_C);
    tempered = t3 ^ (t3 >> 18);
  end

endmodule
`default_nettype wire

// File: src/mersenne_twister_word_generator_unit.sv
// Top level of the MT19937 word generator: a chain of state-word cells, the
// seeder and the twist/temper stage. Depends on mtw_pkg, mtw_cell, mtw_seeder, mtw_twist.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_stall   | in_reseed
//   out     | output    | out_valid / out_stall | out_random_word
//   cfg     | input     | cfg_wr_en             | cfg_wr_data
//
// On a plain draw the chain shifts by one cell and the new word is tempered
// into the output register, so draws sustain one word per cycle while out_stall is low.
// A reseed request, or the first request after reset, first runs the seeder at
// one step per cycle until all STATE_WORDS state words are loaded, and then draws.
// Reset is synchronous and active low; the state words are unseeded after it.
// A stalled result holds the output register; a new request is taken only when
// that register is free or being taken in the same cycle.
`timescale 1ns / 1ps
`default_nettype none
module mersenne_twister_word_generator_unit #(
  parameter int STATE_WORDS   = mtw_pkg::STATE_WORDS,
  parameter int MIDDLE_OFFSET = mtw_pkg::MIDDLE_OFFSET
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_wr_en,
  input  wire mtw_pkg::word_t cfg_wr_data,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic          in_reseed,
  output logic               out_valid,
  input  wire logic          out_stall,
  output mtw_pkg::word_t      out_random_word
);

  localparam int CNT_W = $clog2(STATE_WORDS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SEED = 2'd1;
  localparam logic [1:0] ST_DRAW = 2'd2;

  logic [1:0]      state_r;
  logic [1:0]      state_nxt;
  logic            seeded_r;
  logic            seeded_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  mtw_pkg::word_t  seed_r;
  logic            out_valid_r;
  logic            out_valid_nxt;
  mtw_pkg::word_t  out_word_r;

  logic               out_free;
  logic               in_take;
  logic               draw;
  logic               shift_en;
  mtw_pkg::word_t     shift_in;
  mtw_pkg::seed_ctrl_t seed_ctrl;
  mtw_pkg::word_t     seed_word;
  logic               seed_word_valid;
  mtw_pkg::word_t     new_word;
  mtw_pkg::word_t     tempered;
  mtw_pkg::word_t     chain [STATE_WORDS];

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    state_nxt     = state_r;
    seeded_nxt    = seeded_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    seed_ctrl     = '0;
    draw          = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          if (in_reseed || !seeded_r) begin
            seed_ctrl.load = 1'b1;
            cnt_nxt        = '0;
            state_nxt      = ST_SEED;
          end else begin
            draw = 1'b1;
          end
        end
      end
      ST_SEED: begin
        seed_ctrl.run = 1'b1;
        if (seed_word_valid) begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == CNT_W'(STATE_WORDS - 1)) begin
            seeded_nxt = 1'b1;
            state_nxt  = ST_DRAW;
          end
        end
      end
      ST_DRAW: begin
        if (out_free) begin
          draw      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (draw) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seeded_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      seed_r      <= mtw_pkg::SEED_RESET;
    end else begin
      state_r     <= state_nxt;
      seeded_r    <= seeded_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (draw) begin
      out_word_r <= tempered;
    end
  end

  assign shift_en = draw || seed_word_valid;
  assign shift_in = draw ? new_word : seed_word;

  mtw_seeder u_seeder (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (seed_ctrl),
    .seed       (seed_r),
    .word_out   (seed_word),
    .word_valid (seed_word_valid)
  );

  for (genvar i = 0; i < STATE_WORDS; i++) begin : g_chain
    if (i == STATE_WORDS - 1) begin : g_tail
      mtw_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .d_in     (shift_in),
        .q_out    (chain[i])
      );
    end else begin : g_body
      mtw_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .d_in     (chain[i+1]),
        .q_out    (chain[i])
      );
    end
  end

  mtw_twist u_twist (
    .upper    (chain[0]),
    .lower    (chain[1]),
    .far      (chain[MIDDLE_OFFSET]),
    .new_word (new_word),
    .tempered (tempered)
  );

  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;

endmodule
`default_nettype wire

// File: sim/mersenne_twister_word_generator_unit_tb.sv
// Self-checking testbench for the MT19937 word generator: directed requests from a table,
// then random phases with seed changes, checked word by word against an MT19937 predictor.
// Depends on mtw_pkg and mersenne_twister_word_generator_unit.
`timescale 1ns / 1ps
module mersenne_twister_word_generator_unit_tb;

  localparam mtw_pkg::word_t HALF_MASK = 32'hffff_0000;
  localparam int IDLE_PCT = 19;
  localparam int STALL_LIMIT = 12000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER = 700;
  localparam int DRAIN_CYCLES = 1300;
  localparam int NUM_PHASES = 5;
  localparam int NUM_ROWS = 25;

  typedef struct packed {
    bit write_seed;
    mtw_pkg::word_t seed;
    bit reseed;
  } seq_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  mtw_pkg::word_t cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_reseed = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  mtw_pkg::word_t out_random_word;

  mtw_pkg::word_t mt_words [mtw_pkg::STATE_WORDS];
  int unsigned mt_pos;
  mtw_pkg::word_t mt_seed;
  mtw_pkg::word_t pending_words[$];
  int unsigned mismatch_count = 0;
  int unsigned words_seen = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_left = 0;
  bit hold_done = 1'b0;
  bit calm = 1'b0;

  seq_row_t directed_rows [NUM_ROWS] = '{
    '{1'b0, 32'h0, 1'b0},
    '{1'b0, 32'h0, 1'b0},
    '{1'b0, 32'h0, 1'b1},
    '{1'b0, 32'h0, 1'b0},
    '{1'b1, 32'h0000_0000, 1'b0},
    '{1'b0, 32'h0, 1'b0},
    '{1'b0, 32'h0, 1'b1},
    '{1'b0, 32'h0, 1'b0},
    '{1'b1, 32'hffff_ffff, 1'b0},
    '{1'b0, 32'h0, 1'b1},
    '{1'b0, 32'h0, 1'b0},
    '{1'b0, 32'h0, 1'b1},
    '{1'b0, 32'h0, 1'b1},
    '{1'b1, 32'h0000_0001, 1'b0},
    '{1'b0, 32'h0, 1'b1},
    '{1'b0, 32'h0, 1'b0},
    '{1'b1, 32'h8000_0000, 1'b0},
    '{1'b0, 32'h0, 1'b1},
    '{1'b0, 32'h0, 1'b0},
    '{1'b1, mtw_pkg::SEED_RESET, 1'b0},
    '{1'b0, 32'h0, 1'b1},
    '{1'b0, 32'h0, 1'b0},
    '{1'b1, 32'h7fff_ffff, 1'b0},
    '{1'b0, 32'h0, 1'b1},
    '{1'b0, 32'h0, 1'b0}
  };

  int unsigned phase_items [NUM_PHASES] = '{700, 300, 300, 250, 250};
  int unsigned phase_reseed_pct [NUM_PHASES] = '{0, 2, 5, 1, 3};
  bit phase_calm [NUM_PHASES] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0};

  mersenne_twister_word_generator_unit u_top (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_reseed(in_reseed),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_random_word(out_random_word)
  );

  always #2 clk = ~clk;

  function automatic void fill_from_seed(mtw_pkg::word_t s);
    mtw_pkg::word_t w;
    for (int i = 0; i < mtw_pkg::STATE_WORDS; i++) begin
      w = s & HALF_MASK;
      s = s * mtw_pkg::LCG_MUL + mtw_pkg::LCG_INC;
      w = w | ((s & HALF_MASK) >> 16);
      s = s * mtw_pkg::LCG_MUL + mtw_pkg::LCG_INC;
      mt_words[i] = w;
    end
    mt_pos = mtw_pkg::STATE_WORDS;
  endfunction

  function automatic void twist_words();
    mtw_pkg::word_t y;
    for (int k = 0; k < mtw_pkg::STATE_WORDS; k++) begin
      y = (mt_words[k] & mtw_pkg::HIGH_BIT)
          | (mt_words[(k + 1) % mtw_pkg::STATE_WORDS] & mtw_pkg::LOW_BITS);
      mt_words[k] = mt_words[(k + mtw_pkg::MIDDLE_OFFSET) % mtw_pkg::STATE_WORDS]
                    ^ (y >> 1) ^ (y[0] ? mtw_pkg::TWIST_XOR : 32'h0);
    end
    mt_pos = 0;
  endfunction

  function automatic mtw_pkg::word_t temper_word(mtw_pkg::word_t y);
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & mtw_pkg::TEMPER_B);
    y = y ^ ((y << 15) & mtw_pkg::TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic mtw_pkg::word_t next_mt_word(bit reseed);
    mtw_pkg::word_t w;
    if (reseed) begin
      fill_from_seed(mt_seed);
    end
    if (mt_pos >= mtw_pkg::STATE_WORDS) begin
      if (mt_pos != mtw_pkg::STATE_WORDS) begin
        fill_from_seed(mt_seed);
      end
      twist_words();
    end
    w = temper_word(mt_words[mt_pos % mtw_pkg::STATE_WORDS]);
    mt_pos++;
    return w;
  endfunction

  task automatic send_request(input bit reseed);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_reseed <= reseed;
    do @(posedge clk); while (in_stall);
    pending_words.push_back(next_mt_word(reseed));
  endtask

  task automatic drain_words();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_seed(input mtw_pkg::word_t value);
    drain_words();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mt_seed = value;
  endtask

  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      words_seen++;
      if (pending_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected word %h", out_random_word);
        end
      end else begin
        if (out_random_word !== pending_words[0]) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch on word %0d: expected %h, got %h",
                     words_seen, pending_words[0], out_random_word);
          end
        end
        void'(pending_words.pop_front());
      end
    end
    if (!hold_done && hold_left == 0 && words_seen >= HOLD_AFTER) begin
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      if (hold_left == 0) begin
        hold_done = 1'b1;
      end
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < mtw_pkg::STATE_WORDS; i++) begin
      mt_words[i] = '0;
    end
    mt_pos = mtw_pkg::STATE_WORDS + 1;
    mt_seed = mtw_pkg::SEED_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].write_seed) begin
        write_seed(directed_rows[r].seed);
      end else begin
        send_request(directed_rows[r].reseed);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: write_seed(32'hffff_ffff);
        1: write_seed(32'h0000_0000);
        4: write_seed(mtw_pkg::SEED_RESET);
        default: write_seed($urandom);
      endcase
      calm = phase_calm[p];
      for (int n = 0; n < phase_items[p]; n++) begin
        send_request($urandom_range(0, 99) < phase_reseed_pct[p]);
      end
      calm = 1'b0;
    end

    drain_words();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_words.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/mtw_pkg.sv
src/mtw_cell.sv
src/mtw_seeder.sv
src/mtw_twist.sv
src/mersenne_twister_word_generator_unit.sv
sim/mersenne_twister_word_generator_unit_tb.sv
